FILE: rtl/erq_pkg.sv
// ----------------------------------------------------------------------------
// erq_pkg: shared definitions for the event ring queue
// Action codes, event kinds, compare modes and default sizes.
// ----------------------------------------------------------------------------
package erq_pkg;

  localparam int QUEUE_DEPTH_DEF  = 64;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int ACT_W  = 3;
  localparam int KIND_W = 16;
  localparam int DATA_W = 32;
  localparam int OCC_W  = 7;
  localparam int EXT_W  = 64;   // widest payload the queue may store

  // actions
  localparam logic [ACT_W-1:0] ACT_ADD        = 3'd0;
  localparam logic [ACT_W-1:0] ACT_UNIQUE_ADD = 3'd1;
  localparam logic [ACT_W-1:0] ACT_GET        = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FLUSH_PEN  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_EMPTY      = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SYS_QUERY  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_KEY_QUERY  = 3'd6;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_NIL      = 16'd0;
  localparam logic [KIND_W-1:0] KIND_PEN_DOWN = 16'd1;
  localparam logic [KIND_W-1:0] KIND_PEN_UP   = 16'd2;
  localparam logic [KIND_W-1:0] KIND_PEN_MOVE = 16'd3;
  localparam logic [KIND_W-1:0] KIND_KEY_DOWN = 16'd4;

  // compare modes of the kind matcher
  localparam logic [1:0] MATCH_SAME = 2'd0;  // kind equals reference
  localparam logic [1:0] MATCH_PEN  = 2'd1;  // any pen kind
  localparam logic [1:0] MATCH_SYS  = 2'd2;  // system event pending
  localparam logic [1:0] MATCH_KEY  = 2'd3;  // key down

  typedef struct packed {
    logic [1:0]        mode;
    logic [KIND_W-1:0] ref_kind;
    logic              skip_ups;
  } match_req_t;

endpackage

FILE: rtl/erq_ram.sv
// ----------------------------------------------------------------------------
// erq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module erq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/erq_kind_match.sv
// ----------------------------------------------------------------------------
// erq_kind_match: kind compare unit
// Shared by every scan; the mode picks which kinds count as a hit.
// ----------------------------------------------------------------------------
module erq_kind_match (
  input  erq_pkg::match_req_t            req,
  input  logic [erq_pkg::KIND_W-1:0]     kind,
  output logic                           hit
);

  logic is_down, is_up, is_move, is_key;

  assign is_down = (kind == erq_pkg::KIND_PEN_DOWN);
  assign is_up   = (kind == erq_pkg::KIND_PEN_UP);
  assign is_move = (kind == erq_pkg::KIND_PEN_MOVE);
  assign is_key  = (kind == erq_pkg::KIND_KEY_DOWN);

  always_comb begin
    unique case (req.mode)
      erq_pkg::MATCH_SAME: hit = (kind == req.ref_kind);
      erq_pkg::MATCH_PEN:  hit = is_down || is_up || is_move;
      erq_pkg::MATCH_SYS:  hit = is_down || is_move || is_key || (is_up && !req.skip_ups);
      erq_pkg::MATCH_KEY:  hit = is_key;
      default:             hit = 1'b0;
    endcase
  end

endmodule

FILE: rtl/event_ring_queue_top.sv
// ----------------------------------------------------------------------------
// event_ring_queue_top: circular queue of typed events
// Add, unique add, get, pen flush, empty and pending queries over a ring
// held in RAM, walked by one compare unit under a small sequencer.
// ----------------------------------------------------------------------------
// An item is taken on a clock edge with start high and busy low; busy then
// stays high until the result has been shown. The result appears on the
// result ports for exactly one cycle with done high, and the receiver cannot
// stall it, so it must capture it in that cycle. A get on an empty ring
// goes straight to the result. Queries and unique add walk the queued
// events; a query or an in-place replace ends the walk early on a hit, and
// unique add otherwise appends. Pen flush walks them too and, when at least
// one entry was removed, copies the kept entries back. After done the
// sequencer returns to idle, where the next item is taken. The scan reads
// one entry per cycle, bounded by the RAM read port.
// ----------------------------------------------------------------------------
module event_ring_queue_top #(
  parameter int QUEUE_DEPTH  = erq_pkg::QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BITS = erq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [erq_pkg::ACT_W-1:0]  action,
  input  logic [erq_pkg::KIND_W-1:0] event_kind,
  input  logic [erq_pkg::DATA_W-1:0] event_data,
  input  logic                       replace_in_place,
  input  logic                       ignore_pen_ups,
  output logic                       done,
  output logic [erq_pkg::KIND_W-1:0] popped_kind,
  output logic [erq_pkg::DATA_W-1:0] popped_data,
  output logic                       got_event,
  output logic                       pending,
  output logic                       overflowed,
  output logic [erq_pkg::OCC_W-1:0]  occupancy
);

  localparam int IW = $clog2(QUEUE_DEPTH);        // slot index width
  localparam int CW = $clog2(QUEUE_DEPTH + 1);    // count width
  localparam int P  = PAYLOAD_BITS;
  localparam int EW = erq_pkg::KIND_W + P;        // entry width

  localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
  localparam logic [IW-1:0] LAST_SLOT = IW'(QUEUE_DEPTH - 1);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_GET    = 3'd1;
  localparam logic [2:0] S_APPEND = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_COPY   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] s);
    next_slot = (s == LAST_SLOT) ? '0 : s + IW'(1);
  endfunction

  logic [2:0]    state;
  logic [IW-1:0] head, tail;
  logic [CW-1:0] count;

  // latched item
  logic [erq_pkg::ACT_W-1:0]  act_q;
  logic [erq_pkg::KIND_W-1:0] kind_q;
  logic [P-1:0]               data_q;
  logic                       rip_q, skip_q;

  // scan walker: issue side reads one slot a cycle, examine side sees it
  // in the following cycle when the registered RAM data returns
  logic [IW-1:0] iss_ptr;
  logic [CW-1:0] iss_cnt;
  logic          ex_vld;
  logic [IW-1:0] ex_slot;
  logic [CW-1:0] kept;

  // RAM ports
  logic          main_we, spare_we;
  logic [IW-1:0] main_waddr, main_raddr, spare_raddr;
  logic [EW-1:0] main_wdata, main_rdata, spare_rdata;

  logic [erq_pkg::KIND_W-1:0] rd_kind;
  logic [P-1:0]               rd_data;
  logic [erq_pkg::EXT_W-1:0]  in_ext, pop_ext;

  erq_pkg::match_req_t match_req;
  logic                hit;

  assign rd_kind = main_rdata[EW-1:P];
  assign rd_data = main_rdata[P-1:0];
  assign in_ext  = erq_pkg::EXT_W'(event_data);
  assign pop_ext = erq_pkg::EXT_W'(rd_data);

  assign busy      = (state != S_IDLE);
  assign done      = (state == S_DONE);
  assign occupancy = erq_pkg::OCC_W'(count);

  // compare mode follows the action being scanned
  always_comb begin
    match_req.ref_kind = kind_q;
    match_req.skip_ups = skip_q;
    unique case (act_q)
      erq_pkg::ACT_FLUSH_PEN: match_req.mode = erq_pkg::MATCH_PEN;
      erq_pkg::ACT_SYS_QUERY: match_req.mode = erq_pkg::MATCH_SYS;
      erq_pkg::ACT_KEY_QUERY: match_req.mode = erq_pkg::MATCH_KEY;
      default:                match_req.mode = erq_pkg::MATCH_SAME;
    endcase
  end

  erq_kind_match u_match (
    .req  (match_req),
    .kind (rd_kind),
    .hit  (hit)
  );

  // main ring: event kinds and payloads
  erq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_main (
    .clk   (clk),
    .we    (main_we),
    .waddr (main_waddr),
    .wdata (main_wdata),
    .raddr (main_raddr),
    .rdata (main_rdata)
  );

  // staging area for pen flush: kept entries packed from slot 0
  erq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_spare (
    .clk   (clk),
    .we    (spare_we),
    .waddr (kept[IW-1:0]),
    .wdata (main_rdata),
    .raddr (spare_raddr),
    .rdata (spare_rdata)
  );

  assign main_raddr  = (state == S_SCAN) ? iss_ptr : head;
  assign spare_raddr = iss_cnt[IW-1:0];

  always_comb begin
    main_we    = 1'b0;
    main_waddr = ex_slot;
    main_wdata = main_rdata;
    spare_we   = 1'b0;
    unique case (state)
      S_APPEND: begin
        main_we    = (count != DEPTH_C);
        main_waddr = tail;
        main_wdata = {kind_q, data_q};
      end
      S_SCAN: begin
        // unique add: overwrite the payload in place, or nil the entry
        if (ex_vld && act_q == erq_pkg::ACT_UNIQUE_ADD && hit) begin
          main_we    = 1'b1;
          main_wdata = rip_q ? {rd_kind, data_q} : {erq_pkg::KIND_NIL, rd_data};
        end
        spare_we = ex_vld && act_q == erq_pkg::ACT_FLUSH_PEN && !hit;
      end
      S_COPY: begin
        main_we    = ex_vld;
        main_wdata = spare_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      tail   <= '0;
      count  <= '0;
      ex_vld <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            act_q       <= action;
            kind_q      <= event_kind;
            data_q      <= in_ext[P-1:0];
            rip_q       <= replace_in_place;
            skip_q      <= ignore_pen_ups;
            popped_kind <= '0;
            popped_data <= '0;
            got_event   <= 1'b0;
            pending     <= 1'b0;
            overflowed  <= 1'b0;
            iss_ptr     <= head;
            iss_cnt     <= '0;
            ex_vld      <= 1'b0;
            kept        <= '0;
            unique case (action)
              erq_pkg::ACT_ADD:        state <= S_APPEND;
              erq_pkg::ACT_GET:        state <= (count == '0) ? S_DONE : S_GET;
              erq_pkg::ACT_EMPTY: begin
                count <= '0;
                head  <= '0;
                tail  <= '0;
                state <= S_DONE;
              end
              erq_pkg::ACT_UNIQUE_ADD,
              erq_pkg::ACT_FLUSH_PEN,
              erq_pkg::ACT_SYS_QUERY,
              erq_pkg::ACT_KEY_QUERY:  state <= S_SCAN;
              default:                 state <= S_DONE;
            endcase
          end
        end

        S_GET: begin
          // head read was issued in the accept cycle
          popped_kind <= rd_kind;
          popped_data <= pop_ext[erq_pkg::DATA_W-1:0];
          got_event   <= 1'b1;
          head        <= next_slot(head);
          count       <= count - CW'(1);
          state       <= S_DONE;
        end

        S_APPEND: begin
          if (count == DEPTH_C) begin
            overflowed <= 1'b1;
          end else begin
            tail  <= next_slot(tail);
            count <= count + CW'(1);
          end
          state <= S_DONE;
        end

        S_SCAN: begin
          // an early exit leaves ex_vld as is; the next accept clears it
          if (iss_cnt != count) begin
            iss_ptr <= next_slot(iss_ptr);
            iss_cnt <= iss_cnt + CW'(1);
            ex_slot <= iss_ptr;
            ex_vld  <= 1'b1;
          end else begin
            ex_vld <= 1'b0;
          end
          if (ex_vld) begin
            case (act_q)
              erq_pkg::ACT_UNIQUE_ADD: begin
                if (hit && rip_q) begin
                  state <= S_DONE;
                end
              end
              erq_pkg::ACT_FLUSH_PEN: begin
                if (!hit) begin
                  kept <= kept + CW'(1);
                end
              end
              erq_pkg::ACT_SYS_QUERY,
              erq_pkg::ACT_KEY_QUERY: begin
                if (hit) begin
                  pending <= 1'b1;
                  state   <= S_DONE;
                end
              end
              default: ;
            endcase
          end else if (iss_cnt == count) begin
            // walk finished
            case (act_q)
              erq_pkg::ACT_UNIQUE_ADD: state <= S_APPEND;
              erq_pkg::ACT_FLUSH_PEN: begin
                if (kept != count) begin
                  iss_cnt <= '0;
                  state   <= S_COPY;
                end else begin
                  state <= S_DONE;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end

        S_COPY: begin
          // move kept entries back to slots 0..kept-1
          if (iss_cnt != kept) begin
            iss_cnt <= iss_cnt + CW'(1);
            ex_slot <= iss_cnt[IW-1:0];
            ex_vld  <= 1'b1;
          end else begin
            ex_vld <= 1'b0;
          end
          if (!ex_vld && iss_cnt == kept) begin
            count <= kept;
            head  <= '0;
            tail  <= kept[IW-1:0];
            state <= S_DONE;
          end
        end

        S_DONE: state <= S_IDLE;

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // occupancy never passes the ring size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("queue count above depth");

  // head and tail meet whenever the ring is empty
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (head == tail))
    else $error("empty ring with head and tail apart");

  // a result is followed by an idle cycle in which the next item can be taken
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("sequencer did not return to idle after result");

  // a get result never shows a query hit or an overflow
  a_result_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(got_event && (pending || overflowed)))
    else $error("conflicting result flags");

  // a successful get takes exactly one entry off the ring
  a_get_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_GET) |=> (count == $past(count) - CW'(1)))
    else $error("get did not decrement count");
`endif

endmodule

FILE: tb/sv/event_ring_queue_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// event_ring_queue_checker: scoreboard for the event ring queue
// Keeps a shadow ring, predicts the outcome of every accepted item and checks
// each done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module event_ring_queue_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [erq_pkg::ACT_W-1:0]  action,
  input  logic [erq_pkg::KIND_W-1:0] event_kind,
  input  logic [erq_pkg::DATA_W-1:0] event_data,
  input  logic                       replace_in_place,
  input  logic                       ignore_pen_ups,
  input  logic                       done,
  input  logic [erq_pkg::KIND_W-1:0] popped_kind,
  input  logic [erq_pkg::DATA_W-1:0] popped_data,
  input  logic                       got_event,
  input  logic                       pending,
  input  logic                       overflowed,
  input  logic [erq_pkg::OCC_W-1:0]  occupancy,
  output int                         fail_count,
  output int                         results_due
);

  localparam int DEPTH = erq_pkg::QUEUE_DEPTH_DEF;

  typedef struct {
    logic [erq_pkg::KIND_W-1:0] kind;
    logic [erq_pkg::DATA_W-1:0] data;
    logic                       got;
    logic                       pend;
    logic                       ovf;
    logic [erq_pkg::OCC_W-1:0]  occ;
  } outcome_t;

  logic [erq_pkg::KIND_W-1:0] ring_kind [DEPTH];
  logic [erq_pkg::DATA_W-1:0] ring_data [DEPTH];
  logic [erq_pkg::KIND_W-1:0] kept_kind [DEPTH];
  logic [erq_pkg::DATA_W-1:0] kept_data [DEPTH];
  int                         ring_head;
  int                         ring_tail;
  int                         ring_count;
  outcome_t                   outcomes_due [$];

  function automatic logic is_pen(input logic [erq_pkg::KIND_W-1:0] kind);
    return kind == erq_pkg::KIND_PEN_DOWN || kind == erq_pkg::KIND_PEN_UP ||
           kind == erq_pkg::KIND_PEN_MOVE;
  endfunction

  // returns 1 when the event was dropped on a full ring
  function automatic logic push_event(input logic [erq_pkg::KIND_W-1:0] kind,
                                      input logic [erq_pkg::DATA_W-1:0] data);
    if (ring_count >= DEPTH) return 1'b1;
    ring_kind[ring_tail] = kind;
    ring_data[ring_tail] = data;
    ring_tail  = (ring_tail + 1) % DEPTH;
    ring_count = ring_count + 1;
    return 1'b0;
  endfunction

  task automatic model_item(input logic [erq_pkg::ACT_W-1:0] act,
                            input logic [erq_pkg::KIND_W-1:0] kind,
                            input logic [erq_pkg::DATA_W-1:0] data, input logic rip,
                            input logic ipu, output outcome_t res);
    int   i;
    int   s;
    int   kept;
    logic replaced;
    logic [erq_pkg::KIND_W-1:0] k;
    res = '{kind: '0, data: '0, got: 1'b0, pend: 1'b0, ovf: 1'b0, occ: '0};
    case (act)
      erq_pkg::ACT_ADD: res.ovf = push_event(kind, data);
      erq_pkg::ACT_UNIQUE_ADD: begin
        replaced = 1'b0;
        for (i = 0; i < ring_count; i++) begin
          s = (ring_head + i) % DEPTH;
          if (ring_kind[s] == kind) begin
            if (rip) begin
              ring_data[s] = data;
              replaced = 1'b1;
              break;
            end
            ring_kind[s] = erq_pkg::KIND_NIL;
          end
        end
        if (!replaced) res.ovf = push_event(kind, data);
      end
      erq_pkg::ACT_GET: begin
        if (ring_count > 0) begin
          res.kind   = ring_kind[ring_head];
          res.data   = ring_data[ring_head];
          res.got    = 1'b1;
          ring_head  = (ring_head + 1) % DEPTH;
          ring_count = ring_count - 1;
        end
      end
      erq_pkg::ACT_FLUSH_PEN: begin
        kept = 0;
        for (i = 0; i < ring_count; i++) begin
          s = (ring_head + i) % DEPTH;
          if (!is_pen(ring_kind[s])) begin
            kept_kind[kept] = ring_kind[s];
            kept_data[kept] = ring_data[s];
            kept++;
          end
        end
        // repack from slot 0 only when something was actually removed
        if (kept < ring_count) begin
          for (i = 0; i < kept; i++) begin
            ring_kind[i] = kept_kind[i];
            ring_data[i] = kept_data[i];
          end
          ring_count = kept;
          ring_head  = 0;
          ring_tail  = kept % DEPTH;
        end
      end
      erq_pkg::ACT_EMPTY: begin
        ring_count = 0;
        ring_head  = 0;
        ring_tail  = 0;
      end
      erq_pkg::ACT_SYS_QUERY: begin
        for (i = 0; i < ring_count; i++) begin
          k = ring_kind[(ring_head + i) % DEPTH];
          if (k == erq_pkg::KIND_PEN_DOWN || k == erq_pkg::KIND_PEN_MOVE ||
              k == erq_pkg::KIND_KEY_DOWN || (k == erq_pkg::KIND_PEN_UP && !ipu))
            res.pend = 1'b1;
        end
      end
      erq_pkg::ACT_KEY_QUERY: begin
        for (i = 0; i < ring_count; i++)
          if (ring_kind[(ring_head + i) % DEPTH] == erq_pkg::KIND_KEY_DOWN)
            res.pend = 1'b1;
      end
      default: ;
    endcase
    res.occ = erq_pkg::OCC_W'(ring_count);
  endtask

  task automatic check_field(input string label, input logic [erq_pkg::DATA_W-1:0] want,
                             input logic [erq_pkg::DATA_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    outcome_t due;
    outcome_t predicted;
    if (rst) begin
      ring_head  = 0;
      ring_tail  = 0;
      ring_count = 0;
      outcomes_due.delete();
    end else begin
      // done and a new accept cannot share an edge: busy holds until done
      if (done === 1'b1) begin
        if (outcomes_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual occupancy %0d",
                   $time, occupancy);
        end else begin
          due = outcomes_due.pop_front();
          check_field("popped_kind", erq_pkg::DATA_W'(due.kind),
                      erq_pkg::DATA_W'(popped_kind));
          check_field("popped_data", due.data, popped_data);
          check_field("got_event", erq_pkg::DATA_W'(due.got), erq_pkg::DATA_W'(got_event));
          check_field("pending", erq_pkg::DATA_W'(due.pend), erq_pkg::DATA_W'(pending));
          check_field("overflowed", erq_pkg::DATA_W'(due.ovf),
                      erq_pkg::DATA_W'(overflowed));
          check_field("occupancy", erq_pkg::DATA_W'(due.occ), erq_pkg::DATA_W'(occupancy));
        end
      end
      if (start && !busy) begin
        model_item(action, event_kind, event_data, replace_in_place, ignore_pen_ups,
                   predicted);
        outcomes_due.push_back(predicted);
      end
    end
    results_due <= outcomes_due.size();
  end

endmodule

FILE: tb/sv/event_ring_queue_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// event_ring_queue_top_test: regression for the event ring queue
// Directed corner items, then ~500 random items in fill, drain and mixed
// phases with random sender gaps; a side checker scores every result.
// ----------------------------------------------------------------------------
module event_ring_queue_top_test;

  // the one action code without a meaning; the block just reports occupancy
  localparam logic [erq_pkg::ACT_W-1:0] ACT_UNUSED = 3'd7;

  localparam int RANDOM_ITEMS  = 500;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 80;         // quiet tail after the last result has landed
  localparam int PRESSURE_AT   = 60;         // drain point inside every hundred items

  // random phases: fill pushes toward a full ring (and overflow), drain
  // pops it back to empty, mix is a flat spread over every action code
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIX   = 2;

  logic                       clk              = 1'b0;
  logic                       rst              = 1'b1;
  logic                       start            = 1'b0;
  logic [erq_pkg::ACT_W-1:0]  action           = erq_pkg::ACT_ADD;
  logic [erq_pkg::KIND_W-1:0] event_kind       = erq_pkg::KIND_NIL;
  logic [erq_pkg::DATA_W-1:0] event_data       = '0;
  logic                       replace_in_place = 1'b0;
  logic                       ignore_pen_ups   = 1'b0;
  logic                       busy;
  logic                       done;
  logic [erq_pkg::KIND_W-1:0] popped_kind;
  logic [erq_pkg::DATA_W-1:0] popped_data;
  logic                       got_event;
  logic                       pending;
  logic                       overflowed;
  logic [erq_pkg::OCC_W-1:0]  occupancy;

  int   fail_count;
  int   results_due;
  int   cycle_count = 0;
  logic no_gaps     = 1'b0;  // set during the stretch with back-to-back items

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  event_ring_queue_top dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .action           (action),
    .event_kind       (event_kind),
    .event_data       (event_data),
    .replace_in_place (replace_in_place),
    .ignore_pen_ups   (ignore_pen_ups),
    .done             (done),
    .popped_kind      (popped_kind),
    .popped_data      (popped_data),
    .got_event        (got_event),
    .pending          (pending),
    .overflowed       (overflowed),
    .occupancy        (occupancy)
  );

  event_ring_queue_checker monitor (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .action           (action),
    .event_kind       (event_kind),
    .event_data       (event_data),
    .replace_in_place (replace_in_place),
    .ignore_pen_ups   (ignore_pen_ups),
    .done             (done),
    .popped_kind      (popped_kind),
    .popped_data      (popped_data),
    .got_event        (got_event),
    .pending          (pending),
    .overflowed       (overflowed),
    .occupancy        (occupancy),
    .fail_count       (fail_count),
    .results_due      (results_due)
  );

  // Mostly the named kinds plus one other so unique add finds
  // matches; now and then a full 16-bit code to toggle every bit.
  function automatic logic [erq_pkg::KIND_W-1:0] pick_kind();
    if ($urandom_range(0, 3) != 0) return erq_pkg::KIND_W'($urandom_range(0, 5));
    return erq_pkg::KIND_W'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [erq_pkg::ACT_W-1:0] pick_action(input int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == MODE_MIX) return erq_pkg::ACT_W'($urandom_range(0, 7));
    if (mode == MODE_FILL) begin
      if (r < 55) return erq_pkg::ACT_ADD;
      if (r < 75) return erq_pkg::ACT_UNIQUE_ADD;
      if (r < 82) return erq_pkg::ACT_GET;
      if (r < 88) return erq_pkg::ACT_SYS_QUERY;
      if (r < 93) return erq_pkg::ACT_KEY_QUERY;
      if (r < 96) return erq_pkg::ACT_FLUSH_PEN;
      if (r < 97) return erq_pkg::ACT_EMPTY;
      return ACT_UNUSED;
    end
    // drain
    if (r < 15) return erq_pkg::ACT_ADD;
    if (r < 22) return erq_pkg::ACT_UNIQUE_ADD;
    if (r < 75) return erq_pkg::ACT_GET;
    if (r < 83) return erq_pkg::ACT_SYS_QUERY;
    if (r < 90) return erq_pkg::ACT_KEY_QUERY;
    if (r < 95) return erq_pkg::ACT_FLUSH_PEN;
    if (r < 97) return erq_pkg::ACT_EMPTY;
    return ACT_UNUSED;
  endfunction

  // Present one item and hold it until the edge that takes it (start high,
  // busy low). busy read right after the edge is its pre-edge value, i.e.
  // the value that decided the accept. start stays high into the next item
  // unless a gap is drawn, so it never gets two assignments in one step.
  task automatic issue(input logic [erq_pkg::ACT_W-1:0] act,
                       input logic [erq_pkg::KIND_W-1:0] kind,
                       input logic [erq_pkg::DATA_W-1:0] data, input logic rip,
                       input logic ipu);
    int gap;
    start            <= 1'b1;
    action           <= act;
    event_kind       <= kind;
    event_data       <= data;
    replace_in_place <= rip;
    ignore_pen_ups   <= ipu;
    do @(posedge clk); while (busy);
    // ~30% of items are followed by an idle gap; the gap starts once the
    // block is ready again, so the sender really leaves it idle
    if (!no_gaps && $urandom_range(0, 99) < 30) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 80) : $urandom_range(1, 3);
      start <= 1'b0;
      do @(posedge clk); while (busy);
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off the sender until every outstanding result has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  // run limit; a stuck handshake or a lost result ends up here
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("event_ring_queue_top regression: fail");
    $finish;
  end

  initial begin
    int                        queue_ops;
    int                        mode;
    int                        stretch;
    logic [erq_pkg::ACT_W-1:0] act;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // ---- directed corners ----
    // empty ring: get returns nil, both queries idle
    issue(erq_pkg::ACT_GET, erq_pkg::KIND_PEN_DOWN, 32'hFFFF_FFFF, 1'b1, 1'b1);
    issue(erq_pkg::ACT_SYS_QUERY, erq_pkg::KIND_NIL, '0, 1'b0, 1'b0);
    issue(erq_pkg::ACT_KEY_QUERY, erq_pkg::KIND_NIL, '0, 1'b0, 1'b0);
    // field extremes, then one of each named kind
    issue(erq_pkg::ACT_ADD, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    issue(erq_pkg::ACT_ADD, erq_pkg::KIND_NIL, '0, 1'b0, 1'b0);
    issue(erq_pkg::ACT_ADD, erq_pkg::KIND_PEN_DOWN, 32'h1234_5678, 1'b0, 1'b0);
    issue(erq_pkg::ACT_ADD, erq_pkg::KIND_PEN_UP, 32'h8765_4321, 1'b0, 1'b0);
    issue(erq_pkg::ACT_ADD, erq_pkg::KIND_PEN_MOVE, 32'hA5A5_5A5A, 1'b0, 1'b0);
    issue(erq_pkg::ACT_ADD, erq_pkg::KIND_KEY_DOWN, 32'h0000_0041, 1'b0, 1'b0);
    issue(erq_pkg::ACT_SYS_QUERY, erq_pkg::KIND_NIL, '0, 1'b0, 1'b0);
    issue(erq_pkg::ACT_SYS_QUERY, erq_pkg::KIND_NIL, '0, 1'b0, 1'b1);
    issue(erq_pkg::ACT_KEY_QUERY, erq_pkg::KIND_NIL, '0, 1'b0, 1'b0);
    // unique add: in-place hit, nil-and-append, in-place miss appends
    issue(erq_pkg::ACT_UNIQUE_ADD, erq_pkg::KIND_PEN_DOWN, 32'hDEAD_BEEF, 1'b1, 1'b0);
    issue(erq_pkg::ACT_UNIQUE_ADD, erq_pkg::KIND_PEN_UP, 32'hCAFE_F00D, 1'b0, 1'b0);
    issue(erq_pkg::ACT_UNIQUE_ADD, 16'h00AA, 32'h0BAD_CAFE, 1'b1, 1'b0);
    issue(ACT_UNUSED, erq_pkg::KIND_KEY_DOWN, 32'h5555_AAAA, 1'b1, 1'b1);
    // flush removes pen kinds and repacks; a second flush removes nothing
    issue(erq_pkg::ACT_FLUSH_PEN, erq_pkg::KIND_NIL, '0, 1'b0, 1'b0);
    issue(erq_pkg::ACT_FLUSH_PEN, erq_pkg::KIND_NIL, '0, 1'b0, 1'b0);
    issue(erq_pkg::ACT_GET, erq_pkg::KIND_NIL, '0, 1'b0, 1'b0);
    issue(erq_pkg::ACT_GET, erq_pkg::KIND_NIL, '0, 1'b0, 1'b0);
    issue(erq_pkg::ACT_EMPTY, erq_pkg::KIND_NIL, '0, 1'b0, 1'b0);
    // only a pen up queued: the system query depends on ignore_pen_ups
    issue(erq_pkg::ACT_ADD, erq_pkg::KIND_PEN_UP, 32'h0000_0002, 1'b0, 1'b0);
    issue(erq_pkg::ACT_SYS_QUERY, erq_pkg::KIND_NIL, '0, 1'b0, 1'b1);
    issue(erq_pkg::ACT_SYS_QUERY, erq_pkg::KIND_NIL, '0, 1'b0, 1'b0);
    issue(erq_pkg::ACT_EMPTY, erq_pkg::KIND_NIL, '0, 1'b0, 1'b0);
    drain_results();

    // ---- random phases ----
    // Open with a long fill so the ring reaches full and overflows; later
    // phases are drawn at random. Unused action codes don't count.
    queue_ops = 0;
    mode      = MODE_FILL;
    stretch   = 100;
    while (queue_ops < RANDOM_ITEMS) begin
      if (stretch == 0) begin
        mode    = $urandom_range(MODE_FILL, MODE_MIX);
        stretch = $urandom_range(30, 120);
      end
      stretch--;
      act     = pick_action(mode);
      no_gaps = (queue_ops >= 250 && queue_ops < 350);
      issue(act, pick_kind(), $urandom(), 1'($urandom_range(0, 1)),
            1'($urandom_range(0, 1)));
      if (act != ACT_UNUSED) begin
        queue_ops++;
        if (queue_ops % 100 == PRESSURE_AT) drain_results();
      end
    end

    // let the last results land, then a short quiet tail
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("event_ring_queue_top regression: pass");
    else
      $display("event_ring_queue_top regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/erq_pkg.sv
rtl/erq_ram.sv
rtl/erq_kind_match.sv
rtl/event_ring_queue_top.sv
tb/sv/event_ring_queue_checker.sv
tb/sv/event_ring_queue_top_test.sv
